// ===== rtl/sdes_pkg.sv =====
`timescale 1ns / 1ps

package sdes_pkg;

  // Widths fixed by the cipher.
  localparam int unsigned KeyWidth  = 10;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned HalfWidth = 4;
  localparam int unsigned SubWidth  = 8;

  // Key value after reset (0011011101).
  localparam logic [KeyWidth-1:0] KeyReset = 10'b0011011101;

  // S-box contents, indexed by {row, col}.
  localparam logic [1:0] Sbox0Tab [16] = '{
    2'd1, 2'd0, 2'd3, 2'd2,
    2'd3, 2'd2, 2'd1, 2'd0,
    2'd0, 2'd2, 2'd1, 2'd3,
    2'd3, 2'd1, 2'd3, 2'd2
  };
  localparam logic [1:0] Sbox1Tab [16] = '{
    2'd0, 2'd1, 2'd2, 2'd3,
    2'd2, 2'd0, 2'd1, 2'd3,
    2'd3, 2'd0, 2'd1, 2'd0,
    2'd2, 2'd1, 2'd0, 2'd3
  };

  // The two round keys derived from the cipher key.
  typedef struct packed {
    logic [SubWidth-1:0] k1;
    logic [SubWidth-1:0] k2;
  } round_keys_t;

  // Initial permutation. Position 1 is the most significant bit.
  function automatic logic [ByteWidth-1:0] perm_ip(input logic [ByteWidth-1:0] b);
    return {b[6], b[2], b[5], b[7], b[4], b[0], b[3], b[1]};
  endfunction

  // Inverse of the initial permutation.
  function automatic logic [ByteWidth-1:0] perm_ip_inv(input logic [ByteWidth-1:0] b);
    return {b[4], b[7], b[5], b[3], b[1], b[6], b[0], b[2]};
  endfunction

  function automatic logic [KeyWidth-1:0] perm_p10(input logic [KeyWidth-1:0] k);
    return {k[7], k[5], k[8], k[3], k[6], k[0], k[9], k[1], k[2], k[4]};
  endfunction

  function automatic logic [SubWidth-1:0] perm_p8(input logic [KeyWidth-1:0] v);
    return {v[4], v[7], v[3], v[6], v[2], v[5], v[0], v[1]};
  endfunction

  // Expansion of a 4-bit half to eight bits.
  function automatic logic [SubWidth-1:0] perm_ep(input logic [HalfWidth-1:0] r);
    return {r[0], r[3], r[2], r[1], r[2], r[1], r[0], r[3]};
  endfunction

  function automatic logic [HalfWidth-1:0] perm_p4(input logic [HalfWidth-1:0] s);
    return {s[2], s[0], s[1], s[3]};
  endfunction

  // Row comes from the outer bits, column from the inner bits.
  function automatic logic [1:0] sbox0(input logic [HalfWidth-1:0] x);
    return Sbox0Tab[{x[3], x[0], x[2], x[1]}];
  endfunction

  function automatic logic [1:0] sbox1(input logic [HalfWidth-1:0] x);
    return Sbox1Tab[{x[3], x[0], x[2], x[1]}];
  endfunction

  // Round function F(R, K).
  function automatic logic [HalfWidth-1:0] round_f(input logic [HalfWidth-1:0] r,
                                                   input logic [SubWidth-1:0]  k);
    logic [SubWidth-1:0] e;
    e = perm_ep(r) ^ k;
    return perm_p4({sbox0(e[7:4]), sbox1(e[3:0])});
  endfunction

endpackage

// ===== rtl/sdes_keysched.sv =====
`timescale 1ns / 1ps

module sdes_keysched import sdes_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                key_valid,
  output logic                key_ready,
  input  logic [KeyWidth-1:0] key,
  output round_keys_t         round_keys
);

  logic [KeyWidth-1:0] key_reg;
  logic [KeyWidth-1:0] p10;
  logic [4:0]          half_l1;
  logic [4:0]          half_r1;
  logic [4:0]          half_l3;
  logic [4:0]          half_r3;

  // Writes are always taken.
  assign key_ready = 1'b1;

  // Cipher key register.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_reg <= KeyReset;
    end else if (key_valid) begin
      key_reg <= key;
    end
  end

  // Round keys: rotate each half by one for K1, by three in total for K2.
  always_comb begin
    p10     = perm_p10(key_reg);
    half_l1 = {p10[8:5], p10[9]};
    half_r1 = {p10[3:0], p10[4]};
    half_l3 = {half_l1[2:0], half_l1[4:3]};
    half_r3 = {half_r1[2:0], half_r1[4:3]};
    round_keys.k1 = perm_p8({half_l1, half_r1});
    round_keys.k2 = perm_p8({half_l3, half_r3});
  end

endmodule

// ===== rtl/sdes_round.sv =====
`timescale 1ns / 1ps

module sdes_round import sdes_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_stall,
  input  logic [HalfWidth-1:0] left_in,
  input  logic [HalfWidth-1:0] right_in,
  input  logic [SubWidth-1:0]  subkey,
  output logic                 down_valid,
  input  logic                 down_stall,
  output logic [HalfWidth-1:0] left_out,
  output logic [HalfWidth-1:0] right_out
);

  logic advance;

  // The stage takes a new request when it is empty or its content moves on.
  assign advance  = !down_valid || !down_stall;
  assign up_stall = !advance;

  // Valid bit of the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (advance) begin
      down_valid <= up_valid;
    end
  end

  // One Feistel round: F of the right half is mixed into the left half.
  always_ff @(posedge clk) begin
    if (advance && up_valid) begin
      left_out  <= left_in ^ round_f(right_in, subkey);
      right_out <= right_in;
    end
  end

endmodule

// ===== rtl/sdes_block_encrypt.sv =====
`timescale 1ns / 1ps
// Throughput: one byte per cycle; a stage holds its byte while the next one stalls.
// Stages: round with K1, round with K2, inverse initial permutation into the output register.
// Reset (synchronous, active high) empties the pipeline and loads the key 0011011101.

module sdes_block_encrypt import sdes_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ByteWidth-1:0] plaintext,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ByteWidth-1:0] ciphertext,
  input  logic                 key_valid,
  output logic                 key_ready,
  input  logic [KeyWidth-1:0]  key
);

  round_keys_t          round_keys;
  logic [ByteWidth-1:0] permuted;
  logic                 r1_valid;
  logic                 r1_stall;
  logic [HalfWidth-1:0] r1_left;
  logic [HalfWidth-1:0] r1_right;
  logic                 r2_valid;
  logic                 r2_stall;
  logic [HalfWidth-1:0] r2_left;
  logic [HalfWidth-1:0] r2_right;
  logic                 out_advance;

  sdes_keysched u_keysched (
    .clk        (clk),
    .rst        (rst),
    .key_valid  (key_valid),
    .key_ready  (key_ready),
    .key        (key),
    .round_keys (round_keys)
  );

  assign permuted = perm_ip(plaintext);

  // First round works on the permuted byte.
  sdes_round u_round1 (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (in_valid),
    .up_stall   (in_stall),
    .left_in    (permuted[7:4]),
    .right_in   (permuted[3:0]),
    .subkey     (round_keys.k1),
    .down_valid (r1_valid),
    .down_stall (r1_stall),
    .left_out   (r1_left),
    .right_out  (r1_right)
  );

  // Halves are swapped between the two rounds.
  sdes_round u_round2 (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (r1_valid),
    .up_stall   (r1_stall),
    .left_in    (r1_right),
    .right_in   (r1_left),
    .subkey     (round_keys.k2),
    .down_valid (r2_valid),
    .down_stall (r2_stall),
    .left_out   (r2_left),
    .right_out  (r2_right)
  );

  // Output register with the inverse initial permutation.
  assign out_advance = !out_valid || !out_stall;
  assign r2_stall    = !out_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_advance) begin
      out_valid <= r2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_advance && r2_valid) begin
      ciphertext <= perm_ip_inv({r2_left, r2_right});
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import sdes_pkg::*;

  // Cipher tables, one position per hex digit, first output position in the top digit.
  // Positions count from 1 at the most significant bit; A stands for position 10.
  localparam logic [39:0] P10Order   = 40'h35274A1986;
  localparam logic [39:0] P8Order    = 40'h00637485A9;
  localparam logic [39:0] IpOrder    = 40'h0026314857;
  localparam logic [39:0] IpInvOrder = 40'h0041357286;
  localparam logic [39:0] EpOrder    = 40'h0041232341;
  localparam logic [39:0] P4Order    = 40'h0000002431;

  // S-box entries, two bits each, row-major with entry (0,0) in the top bits.
  localparam logic [31:0] Box0Bits = 32'h4EE427DE;
  localparam logic [31:0] Box1Bits = 32'h1B87C493;

  localparam int unsigned MaxIdle   = 15;
  localparam int unsigned DrainWait = 10;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [ByteWidth-1:0] plaintext;
  logic                 out_valid;
  logic                 out_stall;
  logic [ByteWidth-1:0] ciphertext;
  logic                 key_valid;
  logic                 key_ready;
  logic [KeyWidth-1:0]  key;

  // Key the block is believed to hold, and the ciphertexts still owed by it.
  logic [KeyWidth-1:0]  model_key;
  logic [ByteWidth-1:0] pending_cipher[$];

  // Idle behavior of both sides; an eager side never inserts random gaps.
  bit src_eager;
  bit sink_eager;
  int hold_left;

  int bytes_sent;
  int bytes_checked;
  int keys_loaded;
  int errors;

  sdes_block_encrypt dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .plaintext (plaintext),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ciphertext(ciphertext),
    .key_valid (key_valid),
    .key_ready (key_ready),
    .key       (key)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Generic bit permutation: output bit i+1 takes input position order digit i.
  function automatic logic [9:0] permute(input logic [9:0] v, input int nin, input int m,
                                         input logic [39:0] order);
    logic [9:0] r;
    int         i;
    int         p;
    r = '0;
    for (i = 0; i < m; i++) begin
      p = int'(order[4*(m-1-i) +: 4]);
      r = {r[8:0], v[nin-p]};
    end
    return r;
  endfunction

  function automatic logic [4:0] rotl5(input logic [4:0] h, input int s);
    logic [4:0] r;
    r = (h << s) | (h >> (5 - s));
    return r;
  endfunction

  // Row from the outer bits, column from the inner bits.
  function automatic logic [1:0] sbox_pick(input logic [31:0] bits, input logic [3:0] x);
    int idx;
    idx = int'({x[3], x[0], x[2], x[1]});
    return bits[2*(15-idx) +: 2];
  endfunction

  function automatic logic [3:0] feistel(input logic [3:0] r4, input logic [7:0] k8);
    logic [7:0] e;
    logic [3:0] s;
    logic [9:0] p;
    p = permute({6'b0, r4}, 4, 8, EpOrder);
    e = p[7:0] ^ k8;
    s = {sbox_pick(Box0Bits, e[7:4]), sbox_pick(Box1Bits, e[3:0])};
    p = permute({6'b0, s}, 4, 4, P4Order);
    return p[3:0];
  endfunction

  // Full two-round encryption of one byte under the given key.
  function automatic logic [7:0] encipher(input logic [7:0] pt, input logic [9:0] k);
    logic [9:0] p10;
    logic [9:0] tmp;
    logic [4:0] hl;
    logic [4:0] hr;
    logic [7:0] k1;
    logic [7:0] k2;
    logic [3:0] l;
    logic [3:0] r;
    logic [3:0] t;
    p10 = permute(k, 10, 10, P10Order);
    hl  = rotl5(p10[9:5], 1);
    hr  = rotl5(p10[4:0], 1);
    tmp = permute({hl, hr}, 10, 8, P8Order);
    k1  = tmp[7:0];
    hl  = rotl5(hl, 2);
    hr  = rotl5(hr, 2);
    tmp = permute({hl, hr}, 10, 8, P8Order);
    k2  = tmp[7:0];
    tmp = permute({2'b0, pt}, 8, 8, IpOrder);
    l   = tmp[7:4];
    r   = tmp[3:0];
    l   = l ^ feistel(r, k1);
    t   = l;
    l   = r;
    r   = t;
    l   = l ^ feistel(r, k2);
    tmp = permute({2'b0, l, r}, 8, 8, IpInvOrder);
    return tmp[7:0];
  endfunction

  function automatic int src_gap();
    return src_eager ? 0 : $urandom_range(0, MaxIdle);
  endfunction

  function automatic int sink_gap();
    return sink_eager ? 0 : $urandom_range(0, MaxIdle);
  endfunction

  // Offer one byte and record its ciphertext once the request is taken.
  task automatic send_byte(input logic [ByteWidth-1:0] pt);
    int gap;
    gap = src_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    plaintext <= pt;
    do @(posedge clk); while (in_stall);
    pending_cipher.insert(pending_cipher.size(), encipher(pt, model_key));
    bytes_sent++;
  endtask

  // Stop offering and wait for every owed ciphertext.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cipher.size() != 0) @(posedge clk);
  endtask

  // Key writes happen only with the pipeline empty.
  task automatic load_key(input logic [KeyWidth-1:0] k);
    key_valid <= 1'b1;
    key       <= k;
    do @(posedge clk); while (!key_ready);
    key_valid <= 1'b0;
    model_key = k;
    keys_loaded++;
  endtask

  // Result side: a random stall before each ciphertext, plus an optional long hold-off.
  initial begin : result_sink
    int wait_left;
    wait_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        wait_left = sink_gap();
      end else if (wait_left > 0) begin
        wait_left--;
      end
      if (hold_left > 0) hold_left--;
      out_stall <= (wait_left > 0) || (hold_left > 0);
    end
  end

  // Compare every taken ciphertext with the oldest one owed.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_cipher.size() == 0) begin
        $display("%0t ns: ciphertext expected none, got %02h", $time, ciphertext);
        errors++;
      end else begin
        if (ciphertext !== pending_cipher[0]) begin
          $display("%0t ns: ciphertext expected %02h, got %02h", $time, pending_cipher[0],
                   ciphertext);
          errors++;
        end
        void'(pending_cipher.pop_front());
        bytes_checked++;
      end
    end
  end

  // Extremes and walking bits of the plaintext under the reset key.
  task automatic test_reset_key();
    int i;
    src_eager  = 1'b0;
    sink_eager = 1'b0;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAA);
    for (i = 0; i < ByteWidth; i++) send_byte(8'h01 << i);
    drain();
  endtask

  // Key extremes and single set bits at both ends of the key.
  task automatic test_key_extremes();
    load_key(10'h000);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h3C);
    drain();
    load_key(10'h3FF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hC3);
    drain();
    load_key(10'h200);
    send_byte(8'h81);
    send_byte(8'h7E);
    drain();
    load_key(10'h001);
    send_byte(8'h18);
    send_byte(8'hE7);
    drain();
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall its input.
  task automatic test_backpressure();
    int i;
    load_key(KeyWidth'($urandom_range(0, 1023)));
    src_eager  = 1'b1;
    sink_eager = 1'b1;
    hold_left  = 200;
    for (i = 0; i < 40; i++) send_byte(ByteWidth'($urandom_range(0, 255)));
    drain();
    src_eager  = 1'b0;
    sink_eager = 1'b0;
  endtask

  // Random bytes in phases; each phase loads a key and picks its own idle pattern.
  task automatic test_random();
    int phase;
    int i;
    logic [KeyWidth-1:0] k;
    for (phase = 0; phase < 20; phase++) begin
      case (phase % 5)
        0: k = '0;
        1: k = '1;
        default: k = KeyWidth'($urandom_range(0, 1023));
      endcase
      load_key(k);
      src_eager  = ($urandom_range(0, 3) == 0);
      sink_eager = ($urandom_range(0, 3) == 0);
      for (i = 0; i < 100; i++) begin
        send_byte(ByteWidth'($urandom_range(0, 255)));
        // Now and then the sender waits for everything in flight.
        if ($urandom_range(0, 49) == 0) drain();
      end
      drain();
    end
  endtask

  // Reset, then the tests in turn, then the verdict.
  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    plaintext   = '0;
    out_stall   = 1'b0;
    key_valid   = 1'b0;
    key         = '0;
    model_key   = KeyReset;
    src_eager   = 1'b0;
    sink_eager  = 1'b0;
    hold_left   = 0;
    bytes_sent  = 0;
    bytes_checked = 0;
    keys_loaded = 0;
    errors      = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_key();
    test_key_extremes();
    test_backpressure();
    test_random();

    drain();
    repeat (DrainWait) @(posedge clk);
    if (pending_cipher.size() != 0) begin
      $display("%0t ns: ciphertexts expected %0d more, got none", $time,
               pending_cipher.size());
      errors++;
    end
    $display("Encrypted %0d bytes under %0d key loads; %0d ciphertexts checked, %0d errors.",
             bytes_sent, keys_loaded, bytes_checked, errors);
    $display("Covered reset key, key extremes, long output hold-off and random idling.");
    if (errors == 0) begin
      $display("sdes_block_encrypt: match");
    end else begin
      $display("sdes_block_encrypt: mismatch");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("Timed out waiting for the block.");
    $display("sdes_block_encrypt: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sdes_pkg.sv
rtl/sdes_keysched.sv
rtl/sdes_round.sv
rtl/sdes_block_encrypt.sv
dv/tb_top.sv
